// ----- rtl/clx_pkg.sv -----
// Shared types, codes and character classes for the C-style lexer.
`timescale 1ns / 1ps

package clx_pkg;

    localparam int CHAR_W = 8;
    localparam int LINE_W = 16;
    localparam int MODE_W = 3;

    // Lexer modes.
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLASH  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LCOMM  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BCOMM  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BSTAR  = 3'd6;

    // Token kinds.
    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_OPER   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Request commands.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] chr;
        logic              start;
        logic [LINE_W-1:0] line;
        logic              last;
    } tok_t;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ----- rtl/c_style_lexer_char_stream.sv -----
// Top level of the streaming C-style lexer: input register, lexer state and token queue.
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// text      text_valid, text_ready   cmd, ch
// tok       tok_valid, tok_ready     kind, char_out, token_start, line, last_of_run
//
// A request is taken into the input register and lexed there once the token queue has room,
// so one character enters every cycle while the queue has room; its tokens are written into
// the queue together and reach the tok channel from there, one token at a time.
// The held request is lexed only while the four-entry token queue has room for two
// tokens, so text_ready falls while three or more tokens are queued behind a held request.
// Reset empties the input register and the queue, returns the mode to idle and sets the line counter to one.

module c_style_lexer_char_stream
    import clx_pkg::*;
#(
    parameter int LINE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  logic                 cmd,
    input  logic [CHAR_W-1:0]    ch,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output logic [1:0]           kind,
    output logic [CHAR_W-1:0]    char_out,
    output logic                 token_start,
    output logic [LINE_W-1:0]    line,
    output logic                 last_of_run
);

    // Input register holding the request being lexed.
    logic                 hold_valid_reg;
    logic                 cmd_reg;
    logic [CHAR_W-1:0]    ch_reg;

    // Lexer state, updated when the held request is lexed.
    logic [MODE_W-1:0]    mode_reg;
    logic [MODE_W-1:0]    mode_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;

    logic [1:0]           n_tok;
    tok_t                 tok0;
    tok_t                 tok1;
    tok_t                 head;
    logic                 room2;
    logic                 advance;
    logic [1:0]           push_n;

    // The held request is lexed in the cycle the queue can take both of its
    // possible tokens; a fresh request may enter behind it in that same cycle.
    assign advance    = hold_valid_reg && room2;
    assign text_ready = !hold_valid_reg || room2;
    assign push_n     = advance ? n_tok : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_IDLE;
            line_reg       <= LINE_BITS'(1);
        end
        else
        begin
            if (text_ready)
            begin
                hold_valid_reg <= text_valid;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            cmd_reg <= cmd;
            ch_reg  <= ch;
        end
    end

    clx_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .mode       (mode_reg),
        .line_count (line_reg),
        .cmd        (cmd_reg),
        .ch         (ch_reg),
        .mode_next  (mode_next),
        .line_next  (line_next),
        .n_tok      (n_tok),
        .tok0       (tok0),
        .tok1       (tok1)
    );

    clx_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (tok0),
        .push1     (tok1),
        .room2     (room2),
        .pop_valid (tok_valid),
        .pop_ready (tok_ready),
        .pop_data  (head)
    );

    assign kind        = head.kind;
    assign char_out    = head.chr;
    assign token_start = head.start;
    assign line        = head.line;
    assign last_of_run = head.last;

endmodule

// ----- rtl/clx_step.sv -----
// Next-state and token logic for one character of the lexer.
`timescale 1ns / 1ps

module clx_step
    import clx_pkg::*;
#(
    parameter int LINE_BITS = 16
)
(
    input  logic [MODE_W-1:0]    mode,
    input  logic [LINE_BITS-1:0] line_count,
    input  logic                 cmd,
    input  logic [CHAR_W-1:0]    ch,
    output logic [MODE_W-1:0]    mode_next,
    output logic [LINE_BITS-1:0] line_next,
    output logic [1:0]           n_tok,
    output tok_t                 tok0,
    output tok_t                 tok1
);

    logic [31:0]       line_wide;
    logic [LINE_W-1:0] line_tag;

    // Character handled as if between tokens.
    logic              f_emit;
    logic [1:0]        f_kind;
    logic [MODE_W-1:0] f_mode;
    logic              f_bump;

    logic              e0;
    logic [1:0]        k0;
    logic [CHAR_W-1:0] c0;
    logic              s0;
    logic              e1;
    logic [1:0]        k1;
    logic [CHAR_W-1:0] c1;
    logic              bump;

    assign line_wide = 32'(line_count);
    assign line_tag  = line_wide[LINE_W-1:0];

    always_comb
    begin
        f_emit = 1'b0;
        f_kind = KIND_OPER;
        f_mode = MODE_IDLE;
        f_bump = 1'b0;
        if (is_space(ch))
        begin
            f_bump = (ch == CH_NL);
        end
        else if (is_alpha(ch))
        begin
            f_emit = 1'b1;
            f_kind = KIND_IDENT;
            f_mode = MODE_IDENT;
        end
        else if (is_digit(ch))
        begin
            f_emit = 1'b1;
            f_kind = KIND_NUMBER;
            f_mode = MODE_NUMBER;
        end
        else if (ch == CH_SLASH)
        begin
            f_mode = MODE_SLASH;
        end
        else
        begin
            f_emit = 1'b1;
        end
    end

    always_comb
    begin
        e0        = 1'b0;
        k0        = KIND_OPER;
        c0        = ch;
        s0        = 1'b1;
        e1        = 1'b0;
        k1        = KIND_OPER;
        c1        = ch;
        bump      = 1'b0;
        mode_next = mode;
        if (cmd == CMD_END)
        begin
            mode_next = MODE_IDLE;
            if (mode == MODE_SLASH)
            begin
                e0 = 1'b1;
                c0 = CH_SLASH;
                e1 = 1'b1;
                k1 = KIND_END;
                c1 = CH_NUL;
            end
            else
            begin
                e0 = 1'b1;
                k0 = KIND_END;
                c0 = CH_NUL;
            end
        end
        else
        begin
            unique case (mode)
                MODE_IDENT, MODE_NUMBER:
                begin
                    if ((mode == MODE_IDENT && (is_alpha(ch) || is_digit(ch))) ||
                        (mode == MODE_NUMBER && is_digit(ch)))
                    begin
                        e0 = 1'b1;
                        k0 = (mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
                        s0 = 1'b0;
                    end
                    else
                    begin
                        e0        = f_emit;
                        k0        = f_kind;
                        bump      = f_bump;
                        mode_next = f_mode;
                    end
                end
                MODE_SLASH:
                begin
                    if (ch == CH_SLASH)
                    begin
                        mode_next = MODE_LCOMM;
                    end
                    else if (ch == CH_STAR)
                    begin
                        mode_next = MODE_BCOMM;
                    end
                    else
                    begin
                        // The held slash goes out first, then the new character if it forms a token.
                        e0        = 1'b1;
                        c0        = CH_SLASH;
                        e1        = f_emit;
                        k1        = f_kind;
                        bump      = f_bump;
                        mode_next = f_mode;
                    end
                end
                MODE_LCOMM:
                begin
                    if (ch == CH_NL)
                    begin
                        bump      = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BCOMM:
                begin
                    if (ch == CH_NL)
                    begin
                        bump = 1'b1;
                    end
                    else if (ch == CH_STAR)
                    begin
                        mode_next = MODE_BSTAR;
                    end
                end
                MODE_BSTAR:
                begin
                    if (ch == CH_SLASH)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (ch != CH_STAR)
                    begin
                        bump      = (ch == CH_NL);
                        mode_next = MODE_BCOMM;
                    end
                end
                default:
                begin
                    e0        = f_emit;
                    k0        = f_kind;
                    bump      = f_bump;
                    mode_next = f_mode;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd == CMD_END)
        begin
            line_next = LINE_BITS'(1);
        end
        else if (bump && (line_count != {LINE_BITS{1'b1}}))
        begin
            line_next = line_count + LINE_BITS'(1);
        end
        else
        begin
            line_next = line_count;
        end
    end

    // Pack the results so that the first present one is always in slot zero.
    always_comb
    begin
        tok0 = '{kind: k0, chr: c0, start: s0, line: line_tag, last: 1'b1};
        tok1 = '{kind: k1, chr: c1, start: 1'b1, line: line_tag, last: 1'b1};
        n_tok = 2'd0;
        if (e0 && e1)
        begin
            n_tok     = 2'd2;
            tok0.last = 1'b0;
        end
        else if (e0)
        begin
            n_tok = 2'd1;
        end
        else if (e1)
        begin
            n_tok = 2'd1;
            tok0  = tok1;
        end
    end

endmodule

// ----- rtl/clx_out_fifo.sv -----
// Four-entry token queue that takes up to two tokens a cycle and gives one.
`timescale 1ns / 1ps

module clx_out_fifo
    import clx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  tok_t       push0,
    input  tok_t       push1,
    output logic       room2,
    output logic       pop_valid,
    input  logic       pop_ready,
    output tok_t       pop_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    tok_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= (PTR_W+1)'(DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

endmodule

// ----- rtl/clx_checker.sv -----
// Port-level assertions for the C-style lexer, bound to its top level.
`timescale 1ns / 1ps

module clx_checker
    import clx_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              tok_valid,
    input logic              tok_ready,
    input logic [1:0]        kind,
    input logic [CHAR_W-1:0] char_out,
    input logic              token_start,
    input logic [LINE_W-1:0] line,
    input logic              last_of_run
);

    // A stalled token keeps its contents.
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(kind) && $stable(char_out)
            && $stable(line) && $stable(last_of_run))
        else $error("token changed while stalled");

    // The end token starts a token, carries no character and closes its request.
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && kind == KIND_END |-> token_start && char_out == CH_NUL && last_of_run)
        else $error("malformed end token");

    // Operators are always one character long.
    a_oper_start: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && kind == KIND_OPER |-> token_start)
        else $error("operator without token start");

    // A token that is not the last of its request is the held slash.
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !last_of_run |-> kind == KIND_OPER && char_out == CH_SLASH)
        else $error("unexpected first token of a pair");

    // The line counter starts at one and never wraps to zero.
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> line != '0)
        else $error("line number zero");

endmodule

bind c_style_lexer_char_stream clx_checker u_clx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .kind        (kind),
    .char_out    (char_out),
    .token_start (token_start),
    .line        (line),
    .last_of_run (last_of_run)
);
